/* hw/rtl/ppt_pkg.sv */
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared request codes, status codes, controller command and status types.
// ----------------------------------------------------------------------------
package ppt_pkg;

	localparam int REQ_BITS    = 3;
	localparam int STATUS_BITS = 2;
	localparam int FIELD_BITS  = 16;
	localparam int BOUND_BITS  = 17;

	localparam logic [REQ_BITS-1:0] REQ_INSERT   = 3'd0;
	localparam logic [REQ_BITS-1:0] REQ_MIN_H    = 3'd1;
	localparam logic [REQ_BITS-1:0] REQ_MIN_D    = 3'd2;
	localparam logic [REQ_BITS-1:0] REQ_BOUNDED  = 3'd3;
	localparam logic [REQ_BITS-1:0] REQ_WEIGHTED = 3'd4;

	localparam logic [STATUS_BITS-1:0] ST_PAIR     = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_INSERTED = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_NONE     = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch request, clear walk state
		logic rd_issue;  // read entry at walk index
		logic shift;     // insert walk: compare read entry, move or place
		logic scan;      // query walk: consider read entry
		logic finish;    // form result and present it
	} ppt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic walk_done; // walk is over: index has run off its range, or no later entry qualifies
		logic placed;    // insert walk placed the new pair
	} ppt_sts_t;

endpackage

/* hw/rtl/ppt_ctrl.sv */
// ----------------------------------------------------------------------------
// ppt_ctrl
// Controller: sequences a request through read, walk and result phases.
// ----------------------------------------------------------------------------
module ppt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_busy,
	input  ppt_pkg::ppt_sts_t sts,
	output logic              in_ready,
	output ppt_pkg::ppt_cmd_t cmd
);
	import ppt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				// issue read at current index, or finish when the walk is over or the pair is placed
				if (sts.walk_done || sts.placed) state_d = S_DONE;
				else begin
					cmd.rd_issue = 1'b1;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.shift = 1'b1;
				cmd.scan = 1'b1;
				state_d = S_READ;
			end
			S_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

/* hw/rtl/ppt_dp.sv */
// ----------------------------------------------------------------------------
// ppt_dp
// Datapath: sorted pair memory, walk index, best-so-far compare, result regs.
// ----------------------------------------------------------------------------
module ppt_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ppt_pkg::ppt_cmd_t               cmd,
	output ppt_pkg::ppt_sts_t               sts,
	input  logic [ppt_pkg::REQ_BITS-1:0]    req_type,
	input  logic [ppt_pkg::FIELD_BITS-1:0]  new_h,
	input  logic [ppt_pkg::FIELD_BITS-1:0]  new_d,
	input  logic [ppt_pkg::FIELD_BITS-1:0]  path_cost,
	input  logic [ppt_pkg::BOUND_BITS-1:0]  cost_bound,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [ppt_pkg::FIELD_BITS-1:0]  result_h,
	output logic [ppt_pkg::FIELD_BITS-1:0]  result_d,
	output logic [ppt_pkg::STATUS_BITS-1:0] status,
	output logic                            out_busy
);
	import ppt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int VB = VALUE_BITS;
	localparam int SW = (VB > FIELD_BITS ? VB : FIELD_BITS) + 1; // g + h
	localparam int PW = SW + VB;                                   // (g+h)*d

	logic [2*VB-1:0] mem [TABLE_DEPTH];

	logic [CW-1:0]         count_q;
	logic [REQ_BITS-1:0]   req_q;
	logic [VB-1:0]         nh_q, nd_q;
	logic [FIELD_BITS-1:0] g_q;
	logic [BOUND_BITS-1:0] bound_q;
	logic [CW-1:0]         idx_q;     // insert: slot being filled; scan: next entry
	logic                  done_q, placed_q, found_q;
	logic [VB-1:0]         rh_q, rd_q;
	logic [VB-1:0]         best_h_q, best_d_q;
	logic [PW-1:0]         best_p_q;
	logic [STATUS_BITS-1:0] st_sel;

	logic [AW-1:0] rd_addr;
	logic [SW-1:0] sum;
	logic          in_bound, is_less;
	logic [PW-1:0] prod;

	// insert reads slot-1, queries read slot idx
	assign rd_addr = (req_q == REQ_INSERT) ? AW'(idx_q - CW'(1)) : AW'(idx_q);
	assign sum = SW'(g_q) + SW'(rh_q);
	assign in_bound = (SW'(bound_q) >= sum);
	assign is_less = (nh_q < rh_q) || (nh_q == rh_q && nd_q < rd_q);
	assign prod = PW'(sum) * PW'(rd_q);

	assign sts.walk_done = done_q;
	assign sts.placed    = placed_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) {rh_q, rd_q} <= mem[rd_addr];
		if (cmd.shift && req_q == REQ_INSERT) begin
			if (is_less) mem[AW'(idx_q)] <= {rh_q, rd_q};
			else mem[AW'(idx_q)] <= {nh_q, nd_q};
		end else if (cmd.finish && req_q == REQ_INSERT && idx_q == '0 && !placed_q
			&& count_q < CW'(TABLE_DEPTH)) begin
			mem[AW'(0)] <= {nh_q, nd_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid <= 1'b0;
			done_q <= 1'b0;
			placed_q <= 1'b0;
			found_q <= 1'b0;
			idx_q <= '0;
			req_q <= '0;
			nh_q <= '0;
			nd_q <= '0;
			g_q <= '0;
			bound_q <= '0;
			best_h_q <= '0;
			best_d_q <= '0;
			best_p_q <= '0;
		end else begin
			if (cmd.load) begin
				req_q <= req_type;
				nh_q <= VB'(new_h);
				nd_q <= VB'(new_d);
				g_q <= path_cost;
				bound_q <= cost_bound;
				placed_q <= 1'b0;
				found_q <= 1'b0;
				if (req_type == REQ_INSERT) begin
					idx_q <= count_q;
					done_q <= (count_q == '0) || (count_q == CW'(TABLE_DEPTH));
				end else if (req_type == REQ_BOUNDED || req_type == REQ_WEIGHTED) begin
					idx_q <= '0;
					done_q <= (count_q == '0);
				end else begin
					done_q <= 1'b1; // direct reads handled at finish
					idx_q <= (req_type == REQ_MIN_D) ? CW'(count_q - CW'(1)) : '0;
				end
			end
			if (cmd.shift && req_q == REQ_INSERT) begin
				// move larger entry up, or drop the new pair in this slot
				if (is_less) begin
					idx_q <= idx_q - CW'(1);
					done_q <= (idx_q == CW'(1));
				end else placed_q <= 1'b1;
			end
			if (cmd.scan && req_q != REQ_INSERT) begin
				if (in_bound) begin
					found_q <= 1'b1;
					if (req_q == REQ_BOUNDED || !found_q || prod < best_p_q
						|| (prod == best_p_q && rd_q < best_d_q)) begin
						best_h_q <= rh_q;
						best_d_q <= rd_q;
						best_p_q <= prod;
					end
					idx_q <= idx_q + CW'(1);
					done_q <= (idx_q + CW'(1) == count_q);
				end else done_q <= 1'b1; // qualifying entries form a prefix
			end
			if (cmd.finish) begin
				out_valid <= 1'b1;
				if (req_q == REQ_INSERT && count_q != CW'(TABLE_DEPTH))
					count_q <= count_q + CW'(1);
			end else if (out_valid && out_ready) out_valid <= 1'b0;
		end
	end

	// direct reads (min h / min d) register the entry at load, ahead of finish
	logic [2*VB-1:0] direct_q;
	always_ff @(posedge clk) begin
		if (cmd.load) direct_q <= mem[(req_type == REQ_MIN_D) ? AW'(count_q - CW'(1)) : AW'(0)];
	end

	always_comb begin
		st_sel = ST_NONE;
		unique case (req_q) inside
			REQ_INSERT: st_sel = (count_q == CW'(TABLE_DEPTH)) ? ST_FULL : ST_INSERTED;
			REQ_MIN_H, REQ_MIN_D: st_sel = (count_q == '0) ? ST_NONE : ST_PAIR;
			REQ_BOUNDED, REQ_WEIGHTED: st_sel = found_q ? ST_PAIR : ST_NONE;
			default: st_sel = ST_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status <= st_sel;
			result_h <= '0;
			result_d <= '0;
			if (st_sel == ST_PAIR) begin
				if (req_q == REQ_MIN_H || req_q == REQ_MIN_D) begin
					result_h <= FIELD_BITS'(direct_q[2*VB-1:VB]);
					result_d <= FIELD_BITS'(direct_q[VB-1:0]);
				end else begin
					result_h <= FIELD_BITS'(best_h_q);
					result_d <= FIELD_BITS'(best_d_q);
				end
			end
		end
	end

	assign out_busy = out_valid && !out_ready;
endmodule

/* hw/rtl/pareto_pair_table.sv */
// ----------------------------------------------------------------------------
// pareto_pair_table
// Sorted (h, d) pair table with insert and four min queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with req_type and the operand fields.
//   Each request yields exactly one result on out_valid/out_ready carrying
//   result_h, result_d and status. One request is in flight at a time.
//   Min h and min d read their entry directly. Insert walks down from the
//   end of the table, reading and moving one entry per step; bounded and
//   weighted queries walk up from entry 0, reading one entry per step. A
//   walk covers at most TABLE_DEPTH entries, and the next request is taken
//   only after the current walk finishes, set by the single read port of
//   the pair memory.
//   The result register lets the controller finish the next walk while a
//   result waits; it holds in the done state only while out_valid is stalled.
//   Reset clears the entry count and the handshake state; the pair memory
//   itself is not cleared, since only entries below the count are read.
//   When the receiver stalls, result fields hold until out_ready is seen.
// ----------------------------------------------------------------------------
module pareto_pair_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int VALUE_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ppt_pkg::REQ_BITS-1:0]    req_type,
	input  logic [ppt_pkg::FIELD_BITS-1:0]  new_h,
	input  logic [ppt_pkg::FIELD_BITS-1:0]  new_d,
	input  logic [ppt_pkg::FIELD_BITS-1:0]  path_cost,
	input  logic [ppt_pkg::BOUND_BITS-1:0]  cost_bound,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ppt_pkg::FIELD_BITS-1:0]  result_h,
	output logic [ppt_pkg::FIELD_BITS-1:0]  result_d,
	output logic [ppt_pkg::STATUS_BITS-1:0] status
);
	import ppt_pkg::*;

	ppt_cmd_t cmd;
	ppt_sts_t sts;
	logic     out_busy;

	// controller: accept, walk, hand off result
	ppt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_valid && in_ready),
		.out_busy(out_busy), .sts(sts), .in_ready(in_ready), .cmd(cmd)
	);

	// datapath: memory, compare, result register
	ppt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .new_h(new_h), .new_d(new_d),
		.path_cost(path_cost), .cost_bound(cost_bound),
		.out_ready(out_ready), .out_valid(out_valid),
		.result_h(result_h), .result_d(result_d), .status(status),
		.out_busy(out_busy)
	);
endmodule

/* hw/rtl/ppt_checker.sv */
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks for pareto_pair_table, bound to the top level.
// ----------------------------------------------------------------------------
module ppt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ppt_pkg::FIELD_BITS-1:0]  result_h,
	input logic [ppt_pkg::FIELD_BITS-1:0]  result_d,
	input logic [ppt_pkg::STATUS_BITS-1:0] status
);
	import ppt_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_h))
		else $error("result changed while stalled");

	// one request in flight: no accept in the cycle after an accept
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// non-pair results carry zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_PAIR |-> result_h == '0 && result_d == '0)
		else $error("nonzero fields on non-pair result");

	// no result appears right after an accept
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result too early");
endmodule

bind pareto_pair_table ppt_checker u_ppt_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result_h(result_h),
	.result_d(result_d), .status(status)
);

/* test/pareto_pair_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_pair_table_tb
// Drives random and directed requests into the sorted pair table and checks
// each result against a behavioral copy of the table kept in the bench.
// ----------------------------------------------------------------------------

// Scoreboard: mirrors the sorted table and queues the result each request
// should produce.
class pair_table_scoreboard;
	localparam int DEPTH = 64;

	typedef struct packed {
		logic [15:0] h;
		logic [15:0] d;
		logic [1:0]  st;
	} pair_result_t;

	logic [15:0]  tbl_h[DEPTH];
	logic [15:0]  tbl_d[DEPTH];
	int           fill;
	pair_result_t pending[$];
	int           errors;

	function new();
		fill = 0;
		errors = 0;
	endfunction

	// Note an accepted request: update the mirror table, queue its result.
	function void note_request(logic [2:0] req, logic [15:0] nh, logic [15:0] nd,
			logic [15:0] g, logic [16:0] bound);
		pair_result_t r;
		int pos;
		int best;
		longint unsigned wt;
		longint unsigned best_wt;
		r = '{h: 16'd0, d: 16'd0, st: ppt_pkg::ST_NONE};
		if (req == ppt_pkg::REQ_INSERT) begin
			if (fill >= DEPTH) begin
				r.st = ppt_pkg::ST_FULL;
			end else begin
				pos = fill;
				while (pos > 0 && (nh < tbl_h[pos-1] ||
						(nh == tbl_h[pos-1] && nd < tbl_d[pos-1]))) begin
					tbl_h[pos] = tbl_h[pos-1];
					tbl_d[pos] = tbl_d[pos-1];
					pos--;
				end
				tbl_h[pos] = nh;
				tbl_d[pos] = nd;
				fill++;
				r.st = ppt_pkg::ST_INSERTED;
			end
		end else if (req > ppt_pkg::REQ_WEIGHTED || fill == 0) begin
			r.st = ppt_pkg::ST_NONE;
		end else if (req == ppt_pkg::REQ_MIN_H) begin
			r = '{h: tbl_h[0], d: tbl_d[0], st: ppt_pkg::ST_PAIR};
		end else if (req == ppt_pkg::REQ_MIN_D) begin
			r = '{h: tbl_h[fill-1], d: tbl_d[fill-1], st: ppt_pkg::ST_PAIR};
		end else if (32'(g) + 32'(tbl_h[0]) > 32'(bound)) begin
			r.st = ppt_pkg::ST_NONE;
		end else if (req == ppt_pkg::REQ_BOUNDED) begin
			pos = fill - 1;
			while (pos > 0 && 32'(g) + 32'(tbl_h[pos]) > 32'(bound))
				pos--;
			r = '{h: tbl_h[pos], d: tbl_d[pos], st: ppt_pkg::ST_PAIR};
		end else begin
			best = 0;
			best_wt = (64'(g) + 64'(tbl_h[0])) * 64'(tbl_d[0]);
			for (int i = 1; i < fill && 32'(g) + 32'(tbl_h[i]) <= 32'(bound); i++) begin
				wt = (64'(g) + 64'(tbl_h[i])) * 64'(tbl_d[i]);
				if (wt < best_wt || (wt == best_wt && tbl_d[i] < tbl_d[best])) begin
					best = i;
					best_wt = wt;
				end
			end
			r = '{h: tbl_h[best], d: tbl_d[best], st: ppt_pkg::ST_PAIR};
		end
		pending.insert(pending.size(), r);
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// Compare one accepted result with the oldest queued result.
	task check_result(logic [15:0] h, logic [15:0] d, logic [1:0] st);
		pair_result_t w;
		if (pending.size() == 0) begin
			report("outstanding requests", 0, 1);
			return;
		end
		w = pending.pop_front();
		if (st !== w.st) report("status", st, w.st);
		if (h !== w.h) report("result_h", h, w.h);
		if (d !== w.d) report("result_d", d, w.d);
	endtask
endclass

module pareto_pair_table_tb;
	import ppt_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 720;
	localparam int TABLE_ENTRIES = 64;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [REQ_BITS-1:0]     req_type;
	logic [FIELD_BITS-1:0]   new_h;
	logic [FIELD_BITS-1:0]   new_d;
	logic [FIELD_BITS-1:0]   path_cost;
	logic [BOUND_BITS-1:0]   cost_bound;
	logic                    out_valid;
	logic                    out_ready;
	logic [FIELD_BITS-1:0]   result_h;
	logic [FIELD_BITS-1:0]   result_d;
	logic [STATUS_BITS-1:0]  status;

	pair_table_scoreboard sb;
	bit                   sending_done;
	int                   idle_cycles;

	pareto_pair_table dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .new_h(new_h), .new_d(new_d),
		.path_cost(path_cost), .cost_bound(cost_bound),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_h(result_h), .result_d(result_d), .status(status)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Mostly short gaps, now and then a long one, sometimes none at all.
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Present one request at the falling edge and hold it until accepted.
	task automatic send_request(logic [2:0] req, logic [15:0] h, logic [15:0] d,
			logic [15:0] g, logic [16:0] bound);
		int gap;
		gap = gap_len();
		repeat (gap) @(negedge clk);
		in_valid = 1'b1;
		req_type = req;
		new_h = h;
		new_d = d;
		path_cost = g;
		cost_bound = bound;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_request(req, h, d, g, bound);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Random pair values from a narrow band so ties and duplicates occur,
	// with full-range values mixed in to reach the extremes.
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 7));
			1: return 16'($urandom_range(0, 255));
			2: return 16'($urandom_range(65528, 65535));
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_random();
		logic [2:0]  req;
		logic [15:0] g;
		logic [16:0] bound;
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) req = REQ_INSERT;
		else if (p < 97) req = 3'($urandom_range(1, 4));
		else req = 3'($urandom_range(5, 7));
		g = pick_value();
		// Put half of the bounds near g plus a stored h so some entries qualify.
		case ($urandom_range(0, 3))
			0: bound = 17'($urandom());
			1: bound = 17'(g) + 17'($urandom_range(0, 300));
			2: bound = 17'(g) + 17'(pick_value());
			default: bound = 17'h1ffff;
		endcase
		send_request(req, pick_value(), pick_value(), g, bound);
	endtask

	// Hold the sender until every queued result has drained.
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	// Receiver: random stalls on out_ready, check at the rising edge.
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : (gap_len() == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(result_h, result_d, status);
	end

	// Watchdog: advance a count of cycles with no handshake, fail at the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| sending_done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL pareto_pair_table");
				$finish;
			end
		end
	end

	initial begin
		int waited;
		sb = new();
		sending_done = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_INSERT;
		new_h = '0;
		new_d = '0;
		path_cost = '0;
		cost_bound = '0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: queries on an empty table, unused codes, extreme values.
		send_request(REQ_MIN_H, 16'd0, 16'd0, 16'd0, 17'd0);
		send_request(REQ_MIN_D, 16'd0, 16'd0, 16'd0, 17'd0);
		send_request(REQ_BOUNDED, 16'd0, 16'd0, 16'd0, 17'h1ffff);
		send_request(REQ_WEIGHTED, 16'd0, 16'd0, 16'd0, 17'h1ffff);
		send_request(3'd5, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff);
		send_request(3'd7, 16'd0, 16'd0, 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'hffff, 16'hffff, 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'd0, 16'hffff, 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'd0, 16'd0, 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'd0, 16'd0, 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'd5, 16'd10, 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'd10, 16'd5, 16'd0, 17'd0);
		send_request(REQ_MIN_H, 16'd0, 16'd0, 16'd0, 17'd0);
		send_request(REQ_MIN_D, 16'd0, 16'd0, 16'd0, 17'd0);
		// Nothing qualifies: g alone exceeds the bound.
		send_request(REQ_BOUNDED, 16'd0, 16'd0, 16'hffff, 17'd100);
		send_request(REQ_WEIGHTED, 16'd0, 16'd0, 16'hffff, 17'd100);
		// Largest sum: g + h reaches 0x1fffe against the top bound.
		send_request(REQ_BOUNDED, 16'd0, 16'd0, 16'hffff, 17'h1ffff);
		send_request(REQ_WEIGHTED, 16'd0, 16'd0, 16'hffff, 17'h1ffff);
		send_request(REQ_BOUNDED, 16'd0, 16'd0, 16'd3, 17'd9);
		// Weighted query over the small entries; on equal (g+h)*d the smaller d wins.
		send_request(REQ_WEIGHTED, 16'd0, 16'd0, 16'd5, 17'd20);
		// Fill the table to the top, then one more insert is dropped.
		drain();
		while (sb.fill < TABLE_ENTRIES)
			send_request(REQ_INSERT, pick_value(), pick_value(), 16'd0, 17'd0);
		send_request(REQ_INSERT, 16'd1, 16'd1, 16'd0, 17'd0);
		send_request(REQ_WEIGHTED, 16'd0, 16'd0, 16'd0, 17'h1ffff);
		send_request(REQ_BOUNDED, 16'd0, 16'd0, 16'd0, 17'h1ffff);

		// The table stays full from here, so random queries see a deep table;
		// insert results are all drops. That exercises full-length walks.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2) drain();
			send_random();
		end

		sending_done = 1'b1;
		waited = 0;
		while (sb.pending.size() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (300) @(negedge clk);
		if (sb.pending.size() != 0)
			sb.report("results never arrived", sb.pending.size(), 0);
		if (sb.errors == 0) begin
			$display("PASS pareto_pair_table");
		end else begin
			$display("FAIL pareto_pair_table");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_ctrl.sv
hw/rtl/ppt_dp.sv
hw/rtl/pareto_pair_table.sv
hw/rtl/ppt_checker.sv
test/pareto_pair_table_tb.sv
